/* rtl/handle_pool_allocator_macros.svh */
// ============================================================================
// handle_pool_allocator_macros
// concurrent assertion shorthands used by the allocator back end (hpa_back)
// ============================================================================
`ifndef HANDLE_POOL_ALLOCATOR_MACROS_SVH
`define HANDLE_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define HPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition that must never hold
`define HPA_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

/* rtl/hpa_pkg.sv */
// ============================================================================
// hpa_pkg
// shared widths, types and codes of the handle pool allocator
// ============================================================================
`timescale 1ns / 1ps

package hpa_pkg;

    localparam int POOL_SIZE   = 64;
    localparam int HANDLE_W    = 6;
    localparam int SLOT_W      = 6;
    localparam int STATUS_W    = 2;
    localparam int IDX_W       = $clog2(POOL_SIZE);
    localparam int NEXT_W      = $clog2(POOL_SIZE + 1);

    localparam int GROUP_W     = 8;
    localparam int GRP_IDX_W   = $clog2(GROUP_W);
    localparam int NGROUP      = (POOL_SIZE + GROUP_W - 1) / GROUP_W;
    localparam int SLOT_PAD_W  = NGROUP * GROUP_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [NEXT_W-1:0]    next_t;
    typedef logic [HANDLE_W-1:0]  handle_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [GRP_IDX_W-1:0] grp_idx_t;
    typedef logic [QPTR_W-1:0]    qptr_t;
    typedef logic [QCNT_W-1:0]    qcnt_t;

    typedef enum logic
    {
        KIND_ALLOC,
        KIND_RELEASE
    } kind_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK,
        ST_POOL_EMPTY,
        ST_NOT_ALLOC
    } status_t;

    typedef struct packed
    {
        kind_t   kind;
        handle_t handle;
        logic    in_range;
    } cmd_t;

endpackage

/* rtl/hpa_req_if.sv */
// ============================================================================
// hpa_req_if
// request channel: valid/ready with kind and handle
// ============================================================================
`timescale 1ns / 1ps

interface hpa_req_if;

    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [hpa_pkg::HANDLE_W-1:0]  handle_in;

    modport source
    (
        output valid,
        output kind,
        output handle_in,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  kind,
        input  handle_in,
        output ready
    );

endinterface

/* rtl/hpa_rsp_if.sv */
// ============================================================================
// hpa_rsp_if
// response channel: valid/ready with status, handle and slot
// ============================================================================
`timescale 1ns / 1ps

interface hpa_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [hpa_pkg::STATUS_W-1:0]  status;
    logic [hpa_pkg::HANDLE_W-1:0]  handle_out;
    logic [hpa_pkg::SLOT_W-1:0]    slot_out;

    modport source
    (
        output valid,
        output status,
        output handle_out,
        output slot_out,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  status,
        input  handle_out,
        input  slot_out,
        output ready
    );

endinterface

/* rtl/hpa_front.sv */
// ============================================================================
// hpa_front
// accepts request transactions, decodes them and holds them in a short queue
// ============================================================================
`timescale 1ns / 1ps

module hpa_front
(
    input  logic            clk,
    input  logic            rst_n,
    hpa_req_if.sink         req,
    output logic            q_valid,
    input  logic            q_ready,
    output hpa_pkg::cmd_t   q_cmd
);

    hpa_pkg::cmd_t  q_mem_reg [hpa_pkg::QUEUE_DEPTH];
    hpa_pkg::qptr_t wr_ptr_reg;
    hpa_pkg::qptr_t rd_ptr_reg;
    hpa_pkg::qcnt_t count_reg;
    hpa_pkg::cmd_t  dec_cmd;
    logic           push;
    logic           pop;

    // decode
    always_comb
    begin
        dec_cmd.kind     = hpa_pkg::kind_t'(req.kind);
        dec_cmd.handle   = req.handle_in;
        dec_cmd.in_range = 32'(req.handle_in) < 32'(hpa_pkg::POOL_SIZE);
    end

    assign req.ready = count_reg != hpa_pkg::qcnt_t'(hpa_pkg::QUEUE_DEPTH);
    assign q_valid   = count_reg != '0;
    assign q_cmd     = q_mem_reg[rd_ptr_reg];
    assign push      = req.valid && req.ready;
    assign pop       = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + hpa_pkg::qptr_t'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + hpa_pkg::qptr_t'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + hpa_pkg::qcnt_t'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - hpa_pkg::qcnt_t'(1);
            end
        end
    end

endmodule

/* rtl/hpa_back.sv */
// ============================================================================
// hpa_back
// free-list and slot-table engine: idle reads the memories, exec commits next
// ============================================================================
`timescale 1ns / 1ps
`include "handle_pool_allocator_macros.svh"

module hpa_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  hpa_pkg::cmd_t   q_cmd,
    hpa_rsp_if.source       rsp
);

    typedef enum logic
    {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                             state_reg;
    hpa_pkg::cmd_t                      cmd_reg;
    hpa_pkg::next_t                     head_reg;

    // next-pointer memory, entries not yet written read as their reset chain
    hpa_pkg::next_t                     free_next_mem [hpa_pkg::POOL_SIZE];
    logic [hpa_pkg::POOL_SIZE-1:0]      fn_valid_reg;
    hpa_pkg::next_t                     fn_rd_reg;
    logic                               fn_rd_valid_reg;
    hpa_pkg::idx_t                      fn_rd_addr_reg;
    hpa_pkg::next_t                     fn_rd_data;

    hpa_pkg::idx_t                      handle_slot_mem [hpa_pkg::POOL_SIZE];
    hpa_pkg::idx_t                      hs_rd_reg;

    logic [hpa_pkg::POOL_SIZE-1:0]      slot_used_reg;
    logic [hpa_pkg::POOL_SIZE-1:0]      handle_busy_reg;

    // lowest free slot: per-group search registered, group pick in exec
    logic [hpa_pkg::SLOT_PAD_W-1:0]     slot_pad;
    logic [hpa_pkg::NGROUP-1:0]         grp_free_next;
    logic [hpa_pkg::NGROUP-1:0]         grp_free_reg;
    hpa_pkg::grp_idx_t                  grp_idx_next [hpa_pkg::NGROUP];
    hpa_pkg::grp_idx_t                  grp_idx_reg  [hpa_pkg::NGROUP];
    logic                               ff_found;
    hpa_pkg::idx_t                      ff_idx;

    logic                               rsp_valid_reg;
    hpa_pkg::status_t                   status_reg;
    hpa_pkg::handle_t                   handle_reg;
    hpa_pkg::slot_t                     slot_reg;

    logic                               pop;
    logic                               commit;
    logic                               is_alloc;
    logic                               pool_empty;
    logic                               rel_ok;
    logic                               alloc_do;
    logic                               rel_do;
    hpa_pkg::idx_t                      h_idx;
    hpa_pkg::idx_t                      rel_idx;

    assign q_ready    = state_reg == S_IDLE;
    assign pop        = q_valid && q_ready;
    assign commit     = state_reg == S_EXEC && (!rsp_valid_reg || rsp.ready);
    assign is_alloc   = cmd_reg.kind == hpa_pkg::KIND_ALLOC;
    assign h_idx      = head_reg[hpa_pkg::IDX_W-1:0];
    assign rel_idx    = hpa_pkg::idx_t'(cmd_reg.handle);
    assign pool_empty = head_reg == hpa_pkg::next_t'(hpa_pkg::POOL_SIZE) || !ff_found;
    assign rel_ok     = cmd_reg.in_range && handle_busy_reg[rel_idx];
    assign alloc_do   = commit && is_alloc && !pool_empty;
    assign rel_do     = commit && !is_alloc && rel_ok;
    assign fn_rd_data = fn_rd_valid_reg ? fn_rd_reg
                                        : hpa_pkg::next_t'(fn_rd_addr_reg) + hpa_pkg::next_t'(1);

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.handle_out = handle_reg;
    assign rsp.slot_out   = slot_reg;

    // per-group first zero
    always_comb
    begin
        slot_pad                            = '1;
        slot_pad[hpa_pkg::POOL_SIZE-1:0]    = slot_used_reg;
        grp_free_next                       = '0;
        for (int g = 0; g < hpa_pkg::NGROUP; g++)
        begin
            grp_idx_next[g] = '0;
            for (int b = hpa_pkg::GROUP_W - 1; b >= 0; b--)
            begin
                if (!slot_pad[g * hpa_pkg::GROUP_W + b])
                begin
                    grp_free_next[g] = 1'b1;
                    grp_idx_next[g]  = hpa_pkg::grp_idx_t'(b);
                end
            end
        end
    end

    // lowest non-full group
    always_comb
    begin
        ff_found = 1'b0;
        ff_idx   = '0;
        for (int g = hpa_pkg::NGROUP - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                ff_found = 1'b1;
                ff_idx   = hpa_pkg::idx_t'(g * hpa_pkg::GROUP_W + int'(grp_idx_reg[g]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_free_reg <= '1;
            for (int g = 0; g < hpa_pkg::NGROUP; g++)
            begin
                grp_idx_reg[g] <= '0;
            end
        end
        else
        begin
            grp_free_reg <= grp_free_next;
            grp_idx_reg  <= grp_idx_next;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (rel_do)
        begin
            free_next_mem[rel_idx] <= head_reg;
        end
        if (pop)
        begin
            fn_rd_reg       <= free_next_mem[h_idx];
            fn_rd_valid_reg <= fn_valid_reg[h_idx];
            fn_rd_addr_reg  <= h_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc_do)
        begin
            handle_slot_mem[h_idx] <= ff_idx;
        end
        if (pop)
        begin
            hs_rd_reg <= handle_slot_mem[hpa_pkg::idx_t'(q_cmd.handle)];
        end
    end

    // control, state tables and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= '0;
            head_reg        <= '0;
            fn_valid_reg    <= '0;
            slot_used_reg   <= '0;
            handle_busy_reg <= '0;
            rsp_valid_reg   <= 1'b0;
            status_reg      <= hpa_pkg::ST_OK;
            handle_reg      <= '0;
            slot_reg        <= '0;
        end
        else
        begin
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_cmd;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (commit)
                    begin
                        state_reg <= S_IDLE;
                        if (is_alloc)
                        begin
                            if (pool_empty)
                            begin
                                status_reg <= hpa_pkg::ST_POOL_EMPTY;
                                handle_reg <= '0;
                                slot_reg   <= '0;
                            end
                            else
                            begin
                                status_reg             <= hpa_pkg::ST_OK;
                                handle_reg             <= hpa_pkg::handle_t'(h_idx);
                                slot_reg               <= hpa_pkg::slot_t'(ff_idx);
                                head_reg               <= fn_rd_data;
                                slot_used_reg[ff_idx]  <= 1'b1;
                                handle_busy_reg[h_idx] <= 1'b1;
                            end
                        end
                        else
                        begin
                            handle_reg <= cmd_reg.handle;
                            if (!rel_ok)
                            begin
                                status_reg <= hpa_pkg::ST_NOT_ALLOC;
                                slot_reg   <= '0;
                            end
                            else
                            begin
                                status_reg                 <= hpa_pkg::ST_OK;
                                slot_reg                   <= hpa_pkg::slot_t'(hs_rd_reg);
                                slot_used_reg[hs_rd_reg]   <= 1'b0;
                                handle_busy_reg[rel_idx]   <= 1'b0;
                                fn_valid_reg[rel_idx]      <= 1'b1;
                                head_reg                   <= hpa_pkg::next_t'(rel_idx);
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `HPA_ASSERT_NEVER(a_head_range, head_reg > hpa_pkg::next_t'(hpa_pkg::POOL_SIZE), "free list head out of range")
    `HPA_ASSERT_NXT(a_commit_rsp, commit, rsp_valid_reg && state_reg == S_IDLE, "commit without response")
    `HPA_ASSERT_NXT(a_alloc_busy, alloc_do, handle_busy_reg[$past(h_idx)], "allocated handle not busy")
    `HPA_ASSERT_NXT(a_rel_push, rel_do, !handle_busy_reg[$past(rel_idx)] && head_reg == hpa_pkg::next_t'($past(rel_idx)), "released handle not on top of list")
    `HPA_ASSERT_IMP(a_pop_idle, pop, state_reg == S_IDLE && !commit, "queue pop during commit")

endmodule

/* rtl/handle_pool_allocator.sv */
// ============================================================================
// handle_pool_allocator
// fixed pool of handles with a lifo free list and a lowest-free slot table
// ============================================================================
// A request transaction is accepted into a two-entry queue whenever that
// queue has room, even while a response still waits on the output side.
// The engine then takes one request at a time and pops no new one until
// the last has committed: the idle state reads the next-pointer and
// handle-slot memories, the exec state commits the list head, the slot
// and busy tables and loads the response register once that register is
// free. Allocate returns the top free handle and the lowest free slot,
// or pool empty; release returns the handle's slot, or flags a handle that
// is not allocated. After reset the list holds handles 0 to POOL_SIZE-1 in
// order and no clearing pass is needed.
`timescale 1ns / 1ps

module handle_pool_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    hpa_req_if.sink     req,
    hpa_rsp_if.source   rsp
);

    logic           q_valid;
    logic           q_ready;
    hpa_pkg::cmd_t  q_cmd;

    hpa_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    hpa_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .rsp     (rsp)
    );

endmodule

/* tb/tb.sv */
// ============================================================================
// tb
// self-checking testbench of the handle pool allocator
// ============================================================================
// Request transactions are sent one at a time. Each accepted request runs
// through a predictor of the free list and the active-slot table, and the
// predicted response is queued. A checker compares every accepted response,
// field by field, with the oldest queued response. Directed tests cover the
// reset order of the free list, release of a handle that is not allocated,
// reuse of released handles in last-in-first-out order, and exhaustion of
// the pool. Random tests then fill and drain the pool with mostly valid
// releases and some bogus ones. Both channels idle and stall in random
// bursts, except in the last test.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 12;

    typedef struct
    {
        hpa_pkg::status_t status;
        hpa_pkg::handle_t handle;
        hpa_pkg::slot_t   slot;
    } rsp_item_t;

    logic clk;
    logic rst_n = 1'b0;

    hpa_req_if req_if();
    hpa_rsp_if rsp_if();

    handle_pool_allocator u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // predictor state
    hpa_pkg::next_t   free_next   [hpa_pkg::POOL_SIZE];
    hpa_pkg::next_t   free_head;
    bit               slot_used   [hpa_pkg::POOL_SIZE];
    hpa_pkg::slot_t   handle_slot [hpa_pkg::POOL_SIZE];
    bit               handle_busy [hpa_pkg::POOL_SIZE];

    rsp_item_t due_rsp_q[$];
    int        err_cnt  = 0;
    bit        idle_on  = 1'b1;
    int        quiet_cnt = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void pool_reset();
        for (int i = 0; i < hpa_pkg::POOL_SIZE; i++)
        begin
            free_next[i]   = hpa_pkg::next_t'(i + 1);
            slot_used[i]   = 1'b0;
            handle_slot[i] = '0;
            handle_busy[i] = 1'b0;
        end
        free_head = '0;
    endfunction

    function automatic rsp_item_t pool_predict(input hpa_pkg::kind_t k,
                                               input hpa_pkg::handle_t h);
        rsp_item_t      r;
        int             s;
        hpa_pkg::next_t top;
        hpa_pkg::idx_t  ti;
        r.status = hpa_pkg::ST_POOL_EMPTY;
        r.handle = '0;
        r.slot   = '0;
        if (k == hpa_pkg::KIND_ALLOC)
        begin
            top = free_head;
            if (top >= hpa_pkg::POOL_SIZE)
                return r;
            ti = top[hpa_pkg::IDX_W-1:0];
            s = 0;
            while (s < hpa_pkg::POOL_SIZE && slot_used[s])
                s++;
            if (s >= hpa_pkg::POOL_SIZE)
                return r;
            free_head       = free_next[ti];
            slot_used[s]    = 1'b1;
            handle_slot[ti] = hpa_pkg::slot_t'(s);
            handle_busy[ti] = 1'b1;
            r.status = hpa_pkg::ST_OK;
            r.handle = hpa_pkg::handle_t'(ti);
            r.slot   = hpa_pkg::slot_t'(s);
        end
        else if (!handle_busy[h])
        begin
            r.status = hpa_pkg::ST_NOT_ALLOC;
            r.handle = h;
        end
        else
        begin
            r.status = hpa_pkg::ST_OK;
            r.handle = h;
            r.slot   = handle_slot[h];
            slot_used[handle_slot[h]] = 1'b0;
            handle_busy[h] = 1'b0;
            free_next[h]   = free_head;
            free_head      = hpa_pkg::next_t'(h);
        end
        return r;
    endfunction

    function automatic hpa_pkg::handle_t pick_busy();
        hpa_pkg::handle_t busy_list[$];
        for (int i = 0; i < hpa_pkg::POOL_SIZE; i++)
            if (handle_busy[i])
                busy_list.push_back(hpa_pkg::handle_t'(i));
        if (busy_list.size() == 0)
            return hpa_pkg::handle_t'($urandom);
        return busy_list[$urandom_range(0, busy_list.size() - 1)];
    endfunction

    function automatic int pick_busy_count();
        int n;
        n = 0;
        for (int i = 0; i < hpa_pkg::POOL_SIZE; i++)
            n += handle_busy[i];
        return n;
    endfunction

    // response transaction accepted: compare with the oldest prediction
    always @(posedge clk)
    begin
        rsp_item_t exp_rsp;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (due_rsp_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected response: status %0d handle %0d slot %0d",
                             rsp_if.status, rsp_if.handle_out, rsp_if.slot_out);
            end
            else
            begin
                exp_rsp = due_rsp_q.pop_front();
                if (rsp_if.status !== exp_rsp.status || rsp_if.handle_out !== exp_rsp.handle
                    || rsp_if.slot_out !== exp_rsp.slot)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"mismatch: exp status %0d handle %0d slot %0d, ",
                                  "got status %0d handle %0d slot %0d"},
                                 exp_rsp.status, exp_rsp.handle, exp_rsp.slot,
                                 rsp_if.status, rsp_if.handle_out, rsp_if.slot_out);
                end
            end
        end
    end

    // response side stalls
    initial
    begin
        rsp_if.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cnt <= 0;
            else
                quiet_cnt <= quiet_cnt + 1;
            if (quiet_cnt >= WATCHDOG_LIMIT)
            begin
                $display("handle_pool_allocator regression: fail");
                $finish;
            end
        end
    end

    // ready only moves at the rising edge, so its value at the falling edge
    // is the one seen by the next rising edge
    task automatic send_req(input hpa_pkg::kind_t k, input hpa_pkg::handle_t h);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.kind      <= k;
        req_if.handle_in <= h;
        @(negedge clk);
        while (!req_if.ready)
            @(negedge clk);
        @(posedge clk);
        due_rsp_q.push_back(pool_predict(k, h));
    endtask

    task automatic send_random(input int alloc_pct);
        if ($urandom_range(0, 99) < alloc_pct)
            send_req(hpa_pkg::KIND_ALLOC, hpa_pkg::handle_t'($urandom));
        else if ($urandom_range(0, 4) == 0)
            send_req(hpa_pkg::KIND_RELEASE, hpa_pkg::handle_t'($urandom));
        else
            send_req(hpa_pkg::KIND_RELEASE, pick_busy());
    endtask

    task automatic test_reset_order();
        send_req(hpa_pkg::KIND_ALLOC, '0);
        send_req(hpa_pkg::KIND_ALLOC, '1);
        send_req(hpa_pkg::KIND_ALLOC, 6'h2a);
        send_req(hpa_pkg::KIND_ALLOC, 6'h15);
    endtask

    task automatic test_release_checks();
        send_req(hpa_pkg::KIND_RELEASE, '1);
        send_req(hpa_pkg::KIND_RELEASE, 6'd2);
        send_req(hpa_pkg::KIND_RELEASE, 6'd2);
        send_req(hpa_pkg::KIND_RELEASE, '0);
        send_req(hpa_pkg::KIND_RELEASE, 6'd4);
    endtask

    task automatic test_lifo_reuse();
        send_req(hpa_pkg::KIND_ALLOC, '1);
        send_req(hpa_pkg::KIND_ALLOC, '0);
        send_req(hpa_pkg::KIND_ALLOC, '0);
        send_req(hpa_pkg::KIND_RELEASE, 6'd1);
        send_req(hpa_pkg::KIND_ALLOC, '1);
        send_req(hpa_pkg::KIND_RELEASE, 6'd3);
        send_req(hpa_pkg::KIND_RELEASE, 6'd0);
        send_req(hpa_pkg::KIND_ALLOC, '0);
    endtask

    task automatic test_pool_exhaust();
        while (free_head < hpa_pkg::POOL_SIZE)
            send_req(hpa_pkg::KIND_ALLOC, hpa_pkg::handle_t'($urandom));
        repeat (3) send_req(hpa_pkg::KIND_ALLOC, hpa_pkg::handle_t'($urandom));
        send_req(hpa_pkg::KIND_RELEASE, 6'd63);
        send_req(hpa_pkg::KIND_RELEASE, 6'd63);
        send_req(hpa_pkg::KIND_ALLOC, '0);
        send_req(hpa_pkg::KIND_ALLOC, '0);
        while (pick_busy_count() > 0)
            send_random(0);
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 8; phase++)
            repeat (50) send_random((phase % 2 == 0) ? 80 : 25);
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        repeat (60) send_random(85);
        repeat (60) send_random(30);
    endtask

    initial
    begin
        req_if.valid     <= 1'b0;
        req_if.kind      <= hpa_pkg::KIND_ALLOC;
        req_if.handle_in <= '0;
        pool_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_order();
        test_release_checks();
        test_lifo_reuse();
        test_pool_exhaust();
        test_random_mix();
        test_no_idle();

        req_if.valid <= 1'b0;
        while (due_rsp_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("handle_pool_allocator regression: pass");
        else
            $display("handle_pool_allocator regression: fail");
        $finish;
    end

endmodule
